// ===== design/hsp_pkg.sv =====
// Shared types, constants and hash helpers for the hashed sign projection block.
`default_nettype none
package hsp_pkg;

  localparam int ValueWidth = 24;
  localparam int DiffWidth  = 25;
  localparam int AccWidth   = 38;
  localparam int ScaleWidth = 17;
  localparam int ProdWidth  = AccWidth + ScaleWidth + 1;
  localparam int FracShift  = 16;
  localparam int QuantShift = 11;
  localparam int HashWidth  = 14;

  localparam logic [ScaleWidth-1:0] ScaleReset = 17'h10000;

  localparam logic [31:0] HashFeatureMul = 32'd2654435761;
  localparam logic [31:0] HashCoordMul   = 32'd2246822519;
  localparam logic [HashWidth-1:0] HashStep = HashCoordMul[HashWidth-1:0];
  localparam logic [HashWidth-1:0] HashBase = HashStep * 14'd17;

  localparam logic [ValueWidth-1:0] QuantTop = 24'd8386560;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic                 hbit;
    logic [DiffWidth-1:0] diff;
  } cell_bus_t;

  typedef struct packed {
    logic [ValueWidth-1:0] proj;
    logic [ValueWidth-1:0] quant;
  } result_t;

  // bit 0 xor bit 13 of the feature half of the hash
  function automatic logic hash_sign_key(int unsigned feature);
    logic [31:0] v;
    v = 32'(feature + 1) * HashFeatureMul;
    return v[0] ^ v[13];
  endfunction

endpackage
`default_nettype wire

// ===== design/hsp_cell.sv =====
// One projection cell: holds one feature accumulator and forwards the request to its neighbor.
`default_nettype none
module hsp_cell #(
  parameter logic SignKey = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hsp_pkg::cell_bus_t            bus_i,
  output hsp_pkg::cell_bus_t            bus_o,
  output logic                          emit_o,
  output logic [hsp_pkg::AccWidth-1:0]  result_o
);
  import hsp_pkg::*;

  localparam logic [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  logic [AccWidth-1:0] acc_q, acc_d, sat;
  logic [AccWidth:0]   sum, diff_x;
  cell_bus_t           bus_q;
  logic                add;

  always_comb begin
    add    = SignKey ^ bus_i.hbit;
    diff_x = {{(AccWidth+1-DiffWidth){bus_i.diff[DiffWidth-1]}}, bus_i.diff};
    if (add) begin
      sum = {acc_q[AccWidth-1], acc_q} + diff_x;
    end else begin
      sum = {acc_q[AccWidth-1], acc_q} - diff_x;
    end
    if (sum[AccWidth] != sum[AccWidth-1]) begin
      sat = sum[AccWidth] ? AccMin : AccMax;
    end else begin
      sat = sum[AccWidth-1:0];
    end
    acc_d = acc_q;
    if (bus_i.valid) begin
      acc_d = bus_i.last ? '0 : sat;
    end
    emit_o   = bus_i.valid & bus_i.last;
    result_o = emit_o ? sat : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      bus_q <= '0;
    end else begin
      acc_q <= acc_d;
      bus_q <= bus_i;
    end
  end

  assign bus_o = bus_q;

endmodule
`default_nettype wire

// ===== design/hsp_scaler.sv =====
// Scaling pipeline: multiply by the inverse root scale, round and saturate, quantize.
`default_nettype none
module hsp_scaler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [hsp_pkg::AccWidth-1:0]    acc_i,
  input  logic [hsp_pkg::ScaleWidth-1:0]  scale_i,
  output logic                            valid_o,
  output hsp_pkg::result_t                result_o
);
  import hsp_pkg::*;

  localparam int RndWidth = ProdWidth + 1;
  localparam int SatLow   = FracShift + ValueWidth - 1;
  localparam logic [RndWidth-1:0] HalfUp   = RndWidth'(1) << (FracShift - 1);
  localparam logic [RndWidth-1:0] HalfDown = HalfUp - RndWidth'(1);
  localparam logic [DiffWidth-1:0] QHalfUp   = DiffWidth'(1) << (QuantShift - 1);
  localparam logic [DiffWidth-1:0] QHalfDown = QHalfUp - DiffWidth'(1);
  localparam logic [ValueWidth-1:0] ValMax = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam logic [ValueWidth-1:0] ValMin = {1'b1, {(ValueWidth-1){1'b0}}};

  logic signed [AccWidth-1:0]     acc_s;
  logic signed [ScaleWidth:0]     scale_s;
  logic signed [ProdWidth-1:0]    prod_d;
  logic [ProdWidth-1:0]           prod_q;
  logic                           v1_q, v2_q;
  logic [RndWidth-1:0]            rnd;
  logic [ValueWidth-1:0]          proj_d, proj_q;
  logic [DiffWidth-1:0]           qsum;

  assign acc_s   = acc_i;
  assign scale_s = {1'b0, scale_i};
  assign prod_d  = acc_s * scale_s;

  always_comb begin
    rnd = {prod_q[ProdWidth-1], prod_q}
        + (prod_q[ProdWidth-1] ? HalfDown : HalfUp);
    if (rnd[RndWidth-1:SatLow] != {(RndWidth-SatLow){1'b0}} &&
        rnd[RndWidth-1:SatLow] != {(RndWidth-SatLow){1'b1}}) begin
      proj_d = rnd[RndWidth-1] ? ValMin : ValMax;
    end else begin
      proj_d = rnd[SatLow:FracShift];
    end
  end

  always_comb begin
    qsum = {proj_q[ValueWidth-1], proj_q}
         + (proj_q[ValueWidth-1] ? QHalfDown : QHalfUp);
    result_o.proj = proj_q;
    if (qsum[DiffWidth-1:DiffWidth-2] == 2'b01) begin
      result_o.quant = QuantTop;
    end else begin
      result_o.quant = {qsum[ValueWidth-1:QuantShift], {QuantShift{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= prod_d;
    end
    if (v1_q) begin
      proj_q <= proj_d;
    end
  end

  assign valid_o = v2_q;

endmodule
`default_nettype wire

// ===== design/hsp_result_fifo.sv =====
// Result queue between the scaling pipeline and the output channel.
`default_nettype none
module hsp_result_fifo #(
  parameter int AddrWidth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hsp_pkg::result_t  data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output hsp_pkg::result_t  data_o
);
  import hsp_pkg::*;

  localparam int Depth = 2 ** AddrWidth;

  result_t              mem_q [Depth];
  logic [AddrWidth-1:0] wr_q, rd_q;
  logic [AddrWidth:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule
`default_nettype wire

// ===== design/hashed_sign_projection.sv =====
// Results: the first result of a vector is offered after the input, product, rounded-value and
// result queue registers; the rest follow one per cycle as the consumer takes them.
// Throughput: one coordinate per cycle through the chain of feature cells; a coordinate flagged
// last waits until every result of the previous vector has been taken (the result queue credit).
// Reset: accumulators and coordinate counter clear, scale register returns to 1.0 (65536).
`default_nettype none
module hashed_sign_projection #(
  parameter int FEATURE_COUNT   = 16,
  parameter int QUANTIZED_COUNT = 4,
  parameter int MAX_LENGTH      = 8192
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hsp_pkg::ScaleWidth-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [hsp_pkg::ValueWidth-1:0] clean_value_i,
  input  logic signed [hsp_pkg::ValueWidth-1:0] intervened_value_i,
  input  logic                             last_coordinate_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       feature_index_o,
  output logic signed [hsp_pkg::ValueWidth-1:0] projected_value_o,
  output logic signed [hsp_pkg::ValueWidth-1:0] quantized_value_o,
  output logic                             has_quantized_o,
  output logic                             last_result_o
);
  import hsp_pkg::*;

  localparam int CntWidth = $clog2(MAX_LENGTH);
  localparam int IdxWidth = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int OutWidth = $clog2(FEATURE_COUNT + 1);

  logic [ScaleWidth-1:0] scale_q;
  logic [CntWidth-1:0]   count_q;
  logic [HashWidth-1:0]  hash_q;
  logic [OutWidth-1:0]   outstanding_q;
  logic [IdxWidth-1:0]   idx_q;
  logic                  in_accept, pop;

  cell_bus_t             chain [FEATURE_COUNT];
  logic                  emit [FEATURE_COUNT];
  logic [AccWidth-1:0]   cell_res [FEATURE_COUNT];
  logic                  emit_any;
  logic [AccWidth-1:0]   emit_acc;

  logic                  sc_valid;
  result_t               sc_result, head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = last_coordinate_i && (outstanding_q != '0);
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hash_q  <= HashBase;
    end else if (in_accept) begin
      if (last_coordinate_i || count_q == CntWidth'(MAX_LENGTH - 1)) begin
        count_q <= '0;
        hash_q  <= HashBase;
      end else begin
        count_q <= count_q + 1'b1;
        hash_q  <= hash_q + HashStep;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else begin
      chain[0].valid <= in_accept;
      chain[0].last  <= last_coordinate_i;
      chain[0].hbit  <= hash_q[0] ^ hash_q[HashWidth-1];
      chain[0].diff  <= DiffWidth'(intervened_value_i) - DiffWidth'(clean_value_i);
    end
  end

  for (genvar f = 0; f < FEATURE_COUNT; f++) begin : g_cell
    if (f < FEATURE_COUNT - 1) begin : g_mid
      hsp_cell #(
        .SignKey (hash_sign_key(f))
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .bus_i    (chain[f]),
        .bus_o    (chain[f+1]),
        .emit_o   (emit[f]),
        .result_o (cell_res[f])
      );
    end else begin : g_end
      hsp_cell #(
        .SignKey (hash_sign_key(f))
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .bus_i    (chain[f]),
        .bus_o    (),
        .emit_o   (emit[f]),
        .result_o (cell_res[f])
      );
    end
  end

  // at most one cell emits per cycle
  always_comb begin
    emit_any = 1'b0;
    emit_acc = '0;
    for (int f = 0; f < FEATURE_COUNT; f++) begin
      emit_any = emit_any | emit[f];
      emit_acc = emit_acc | cell_res[f];
    end
  end

  hsp_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (emit_any),
    .acc_i    (emit_acc),
    .scale_i  (scale_q),
    .valid_o  (sc_valid),
    .result_o (sc_result)
  );

  hsp_result_fifo #(
    .AddrWidth (IdxWidth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sc_valid),
    .data_i  (sc_result),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (head)
  );

  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
      idx_q         <= '0;
    end else begin
      if (in_accept && last_coordinate_i) begin
        outstanding_q <= outstanding_q + OutWidth'(FEATURE_COUNT);
      end else if (pop) begin
        outstanding_q <= outstanding_q - 1'b1;
      end
      if (pop) begin
        idx_q <= (idx_q == IdxWidth'(FEATURE_COUNT - 1)) ? '0 : idx_q + 1'b1;
      end
    end
  end

  assign feature_index_o   = 4'(idx_q);
  assign has_quantized_o   = (int'(idx_q) < QUANTIZED_COUNT);
  assign last_result_o     = (idx_q == IdxWidth'(FEATURE_COUNT - 1));
  assign projected_value_o = head.proj;
  assign quantized_value_o = has_quantized_o ? head.quant : '0;

endmodule
`default_nettype wire
